// File: design/lsps_pkg.sv
// Shared types and constants for the LED strip pulse serializer.
// No dependencies; every design file but lsps_queue refers to this package by scoped names.
package lsps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 11;
    localparam int TICK_W     = 16;

    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - TICK_W - 1;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ZERO_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ONE_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS       = 3'd5;

    localparam logic [CNT_W-1:0]  RST_PIXEL_COUNT     = 11'd1;
    localparam logic [TICK_W-1:0] RST_HIGH_ZERO_TICKS = 16'd26;
    localparam logic [TICK_W-1:0] RST_HIGH_ONE_TICKS  = 16'd52;
    localparam logic [TICK_W-1:0] RST_LOW_ZERO_TICKS  = 16'd38;
    localparam logic [TICK_W-1:0] RST_LOW_ONE_TICKS   = 16'd12;
    localparam logic [TICK_W-1:0] RST_GAP_TICKS       = 16'd500;

    typedef struct packed {
        logic [CNT_W-1:0]  pixel_count;
        logic [TICK_W-1:0] high_zero_ticks;
        logic [TICK_W-1:0] high_one_ticks;
        logic [TICK_W-1:0] low_zero_ticks;
        logic [TICK_W-1:0] low_one_ticks;
        logic [TICK_W-1:0] gap_ticks;
    } cfg_t;

endpackage

// File: design/lsps_cfg.sv
// Configuration register file for the LED strip pulse serializer.
// Depends on lsps_pkg for register indexes, reset values and cfg_t.
module lsps_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lsps_pkg::cfg_t                   cfg
);

    lsps_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_count     <= lsps_pkg::RST_PIXEL_COUNT;
            cfg_reg.high_zero_ticks <= lsps_pkg::RST_HIGH_ZERO_TICKS;
            cfg_reg.high_one_ticks  <= lsps_pkg::RST_HIGH_ONE_TICKS;
            cfg_reg.low_zero_ticks  <= lsps_pkg::RST_LOW_ZERO_TICKS;
            cfg_reg.low_one_ticks   <= lsps_pkg::RST_LOW_ONE_TICKS;
            cfg_reg.gap_ticks       <= lsps_pkg::RST_GAP_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lsps_pkg::REG_PIXEL_COUNT: begin
                    cfg_reg.pixel_count <= cfg_data[lsps_pkg::CNT_W-1:0];
                end
                lsps_pkg::REG_HIGH_ZERO_TICKS: begin
                    cfg_reg.high_zero_ticks <= cfg_data;
                end
                lsps_pkg::REG_HIGH_ONE_TICKS: begin
                    cfg_reg.high_one_ticks <= cfg_data;
                end
                lsps_pkg::REG_LOW_ZERO_TICKS: begin
                    cfg_reg.low_zero_ticks <= cfg_data;
                end
                lsps_pkg::REG_LOW_ONE_TICKS: begin
                    cfg_reg.low_one_ticks <= cfg_data;
                end
                lsps_pkg::REG_GAP_TICKS: begin
                    cfg_reg.gap_ticks <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: design/lsps_front.sv
// Front end: accepts pixels, tracks the frame position, tags the last pixel
// of each frame and pushes it to the queue. Depends on lsps_pkg.
module lsps_front #(
    parameter int BITS_PER_PIXEL = 24,
    parameter int MAX_PIXELS     = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lsps_pkg::CNT_W-1:0]    pixel_count,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [BITS_PER_PIXEL-1:0]     s_color,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [BITS_PER_PIXEL:0]       q_data
);

    localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [31:0]   cnt_eff;
    logic          frame_done;

    always_comb begin
        if (pixel_count == '0) begin
            cnt_eff = 32'd1;
        end else if (32'(pixel_count) > 32'(MAX_PIXELS)) begin
            cnt_eff = 32'(MAX_PIXELS);
        end else begin
            cnt_eff = 32'(pixel_count);
        end
        frame_done = (32'(pos_reg) + 32'd1) >= cnt_eff;
        pos_next   = frame_done ? '0 : pos_reg + PW'(1);
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = {frame_done, s_color};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (q_push) begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: design/lsps_queue.sv
// Two-entry queue between the front end and the segment generator.
// No package dependencies.
module lsps_queue #(
    parameter int WIDTH = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: design/lsps_back.sv
// Back end: walks the bits of one queued pixel, emits high/low segments and
// the frame gap into an output register. Depends on lsps_pkg for cfg_t.
module lsps_back #(
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lsps_pkg::cfg_t                       cfg,
    input  logic                                 q_valid,
    input  logic [BITS_PER_PIXEL:0]              q_data,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lsps_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);

    localparam int BCW = (BITS_PER_PIXEL > 1) ? $clog2(BITS_PER_PIXEL) : 1;

    typedef enum logic [3:0] {
        SEG_IDLE = 4'b0001,
        SEG_HIGH = 4'b0010,
        SEG_LOW  = 4'b0100,
        SEG_GAP  = 4'b1000
    } seg_state_t;

    seg_state_t                    state_reg, state_next;
    logic [BITS_PER_PIXEL-1:0]     color_reg, color_next;
    logic                          fdone_reg, fdone_next;
    logic [BCW-1:0]                bit_cnt_reg, bit_cnt_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          level_reg;
    logic [lsps_pkg::TICK_W-1:0]   dur_reg;
    logic                          last_reg;
    logic                          fend_reg;

    logic                          cur_bit;
    logic                          last_bit;
    logic                          seg_valid;
    logic                          seg_level;
    logic [lsps_pkg::TICK_W-1:0]   seg_dur;
    logic                          seg_last;
    logic                          seg_fend;
    logic                          seg_done;
    logic                          out_load;
    logic                          issue;

    always_comb begin
        cur_bit   = color_reg[BITS_PER_PIXEL-1];
        last_bit  = bit_cnt_reg == BCW'(BITS_PER_PIXEL - 1);
        seg_valid = state_reg != SEG_IDLE;
        seg_level = 1'b0;
        seg_dur   = '0;
        seg_last  = 1'b0;
        seg_fend  = 1'b0;
        seg_done  = 1'b0;
        case (state_reg)
            SEG_HIGH: begin
                seg_level = 1'b1;
                seg_dur   = cur_bit ? cfg.high_one_ticks : cfg.high_zero_ticks;
            end
            SEG_LOW: begin
                seg_dur  = cur_bit ? cfg.low_one_ticks : cfg.low_zero_ticks;
                seg_last = last_bit && !fdone_reg;
                seg_done = last_bit && !fdone_reg;
            end
            SEG_GAP: begin
                seg_dur  = cfg.gap_ticks;
                seg_last = 1'b1;
                seg_fend = 1'b1;
                seg_done = 1'b1;
            end
            default: begin
            end
        endcase

        out_load = !m_tvalid_reg || m_tready;
        issue    = seg_valid && out_load;
        q_pop    = q_valid && (!seg_valid || (issue && seg_done));

        state_next    = state_reg;
        color_next    = color_reg;
        fdone_next    = fdone_reg;
        bit_cnt_next  = bit_cnt_reg;
        m_tvalid_next = out_load ? seg_valid : m_tvalid_reg;

        if (issue) begin
            case (state_reg)
                SEG_HIGH: begin
                    state_next = SEG_LOW;
                end
                SEG_LOW: begin
                    if (!last_bit) begin
                        state_next   = SEG_HIGH;
                        color_next   = color_reg << 1;
                        bit_cnt_next = bit_cnt_reg + BCW'(1);
                    end else if (fdone_reg) begin
                        state_next = SEG_GAP;
                    end else begin
                        state_next = SEG_IDLE;
                    end
                end
                default: begin
                    state_next = SEG_IDLE;
                end
            endcase
        end

        if (q_pop) begin
            state_next   = SEG_HIGH;
            color_next   = q_data[BITS_PER_PIXEL-1:0];
            fdone_next   = q_data[BITS_PER_PIXEL];
            bit_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SEG_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        color_reg   <= color_next;
        fdone_reg   <= fdone_next;
        bit_cnt_reg <= bit_cnt_next;
        if (issue) begin
            level_reg <= seg_level;
            dur_reg   <= seg_dur;
            last_reg  <= seg_last;
            fend_reg  <= seg_fend;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{lsps_pkg::OUT_PAD_W{1'b0}}, dur_reg, level_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = fend_reg;

endmodule

// File: design/led_strip_pulse_serializer_top.sv
// Top level of the LED strip pulse serializer: config registers, front end,
// pixel queue and segment generator. Depends on lsps_pkg and all lsps_* modules.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid/s_tready    tdata = pixel_color
//   m_       out        m_tvalid/m_tready    tdata = line_level, duration_ticks;
//                                            tlast = last_of_item; tuser = frame_end
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One segment leaves per cycle while m_tready is high and pixels are queued:
// a pixel gives 2*BITS_PER_PIXEL segments (48), plus one gap segment on the
// last pixel of a frame. A two-entry queue holds the next pixels, so they
// follow without a bubble. Reset restores register defaults, clears the frame
// position and empties the queue. A stalled m_ side holds the output
// register; the s_ side stalls only when the queue is full.
module led_strip_pulse_serializer_top #(
    parameter int BITS_PER_PIXEL = 24,
    parameter int MAX_PIXELS     = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((BITS_PER_PIXEL+7)/8)*8-1:0]  s_tdata,   // pixel_color
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lsps_pkg::OUT_TDATA_W-1:0]     m_tdata,   // line_level, duration_ticks
    output logic                                 m_tlast,
    output logic                                 m_tuser,   // frame_end
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    lsps_pkg::cfg_t              cfg;
    logic                        q_full;
    logic                        q_push;
    logic [BITS_PER_PIXEL:0]     q_wdata;
    logic                        q_pop;
    logic                        q_valid;
    logic [BITS_PER_PIXEL:0]     q_rdata;

    lsps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsps_front #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL),
        .MAX_PIXELS     (MAX_PIXELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pixel_count (cfg.pixel_count),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_color     (s_tdata[BITS_PER_PIXEL-1:0]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    lsps_queue #(
        .WIDTH (BITS_PER_PIXEL + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    lsps_back #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
